// ===== rtl/bba_pkg.sv =====
// Shared constants, codes and types of the bitmap buffer allocator.
package bba_pkg;

    localparam int NUM_BUFS_DEF    = 64;
    localparam int BLOCK_BYTES_DEF = 4096;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SEL_W = 5;

    localparam int OFFSET_W = 18;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] BUFFER_COUNT_RST = 7'd64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POOL_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FREE_RD,
        S_SCAN,
        S_OFS,
        S_DONE
    } state_t;

endpackage

// ===== rtl/bitmap_buffer_allocator_top.sv =====
// Top level of the bitmap buffer allocator: in-use bitmap memory and request sequencer.
// Steps: a free passes S_DIV, S_FREE_RD and S_DONE (S_DIV straight to S_DONE when out of
// range); an allocate passes S_SCAN, one bitmap row a cycle, then S_OFS and S_DONE (S_SCAN
// straight to S_DONE if no buffer is free). One request at a time: the next word is taken
// in S_IDLE, after the result is loaded into the output register.
// Reset (synchronous): row valid flags, counters and output valid clear, buffer_count returns to 64.
module bitmap_buffer_allocator_top
    import bba_pkg::*;
#(
    parameter int NUM_BUFS    = NUM_BUFS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [OFFSET_W-1:0] s_free_offset,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [OFFSET_W-1:0] m_alloc_offset,
    output logic [STATUS_W-1:0] m_status,
    output logic [COUNT_W-1:0]  m_in_use_count,
    output logic [COUNT_W-1:0]  m_peak_count
);

    // Bitmap geometry: rows of WORD_BITS flags held in a small synchronous memory.
    localparam int MAP_WORDS = (NUM_BUFS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FI_W      = ADDR_W + WORD_SEL_W;

    // Counter widths: counts run up to NUM_BUFS.
    localparam int CNT_W = $clog2(NUM_BUFS + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SC_W  = ((CNT_W > FI_W) ? CNT_W : FI_W) + 1;

    // Offset to index is a multiplication by a rounded-up reciprocal, exact for every
    // 18-bit offset.
    localparam int          DIV_L = $clog2(BLOCK_BYTES);
    localparam int          DIV_S = OFFSET_W + DIV_L;
    localparam longint      DIV_M = ((64'd1 << DIV_S) / BLOCK_BYTES) + 1;
    localparam int          M_W   = $clog2(DIV_M + 1);
    localparam int          PROD_W = OFFSET_W + M_W;
    localparam int          Q_MAX = ((1 << OFFSET_W) - 1) / BLOCK_BYTES;
    localparam int          Q_W   = (Q_MAX > 0) ? $clog2(Q_MAX + 1) : 1;
    localparam int          QC_W  = (Q_W > SC_W) ? Q_W : SC_W;

    // Index to byte offset product.
    localparam int OP_W = (OFFSET_W > FI_W + 17) ? OFFSET_W : FI_W + 17;

    // Control state and request registers.
    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  buffer_count_reg;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ADDR_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [FI_W-1:0]     idx_reg, idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OFFSET_W-1:0] res_ofs_reg, res_ofs_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    peak_reg, peak_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [OFFSET_W-1:0] m_alloc_offset_reg, m_alloc_offset_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [COUNT_W-1:0]  m_in_use_reg, m_in_use_next;
    logic [COUNT_W-1:0]  m_peak_reg, m_peak_next;

    // Bitmap memory. A row whose valid flag is clear reads as all free.
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_valid_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rvalid_reg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Derived values.
    logic [CMP_W-1:0]     bc_x, nb_x, eff_x;
    logic [CNT_W-1:0]     cnt;
    logic [WORD_BITS-1:0] row_word;
    logic [SC_W-1:0]      base_x, cnt_sx, rem_x;
    logic [WORD_BITS-1:0] cand;
    logic                 found;
    logic [WORD_SEL_W-1:0] found_pos;
    logic                 last_row;
    logic [PROD_W-1:0]    prod_sh;
    logic [Q_W-1:0]       q;
    logic [QC_W-1:0]      q_x, cnt_qx;
    logic [FI_W-1:0]      q_idx;
    logic [OP_W-1:0]      ofs_prod;
    logic [CMP_W-1:0]     total_x, peak_x;
    logic                 out_load;

    // The effective pool size saturates at the built size.
    assign bc_x  = CMP_W'(buffer_count_reg);
    assign nb_x  = CMP_W'(NUM_BUFS);
    assign eff_x = (bc_x < nb_x) ? bc_x : nb_x;
    assign cnt   = CNT_W'(eff_x);

    assign row_word = rvalid_reg ? rdata_reg : '0;

    // Only flags below the effective count take part in the search.
    assign base_x   = SC_W'({scan_addr_reg, {WORD_SEL_W{1'b0}}});
    assign cnt_sx   = SC_W'(cnt);
    assign rem_x    = (cnt_sx > base_x) ? (cnt_sx - base_x) : '0;
    assign last_row = (base_x + SC_W'(WORD_BITS)) >= cnt_sx;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            cand[b] = !row_word[b] && (SC_W'(b) < rem_x);
        end
    end

    // Lowest free flag of the row.
    always_comb begin
        found     = 1'b0;
        found_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                found     = 1'b1;
                found_pos = WORD_SEL_W'(b);
            end
        end
    end

    // Quotient of the registered reciprocal product.
    assign prod_sh = prod_reg >> DIV_S;
    assign q       = prod_sh[Q_W-1:0];
    assign q_x     = QC_W'(q);
    assign cnt_qx  = QC_W'(cnt);
    assign q_idx   = FI_W'(q_x);

    assign ofs_prod = OP_W'(idx_reg) * OP_W'(BLOCK_BYTES);

    assign total_x = CMP_W'(total_next);
    assign peak_x  = CMP_W'(peak_next);

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_alloc_offset = m_alloc_offset_reg;
    assign m_status       = m_status_reg;
    assign m_in_use_count = m_in_use_reg;
    assign m_peak_count   = m_peak_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_FREE) ? S_DIV : S_SCAN;
                end
            end
            S_DIV: begin
                state_next = (q_x >= cnt_qx) ? S_DONE : S_FREE_RD;
            end
            S_FREE_RD: begin
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (found) begin
                    state_next = S_OFS;
                end else if (last_row) begin
                    state_next = S_DONE;
                end
            end
            S_OFS: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control and memory accesses.
    always_comb begin
        prod_next      = prod_reg;
        scan_addr_next = scan_addr_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        res_ofs_next   = res_ofs_reg;
        total_next     = total_reg;
        peak_next      = peak_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = scan_addr_reg;
        wr_data        = row_word;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    prod_next      = PROD_W'(s_free_offset) * PROD_W'(DIV_M);
                    scan_addr_next = '0;
                    status_next    = ST_OK;
                    res_ofs_next   = '0;
                    rd_en          = (s_op == OP_ALLOC);
                    rd_addr        = '0;
                end
            end
            S_DIV: begin
                idx_next = q_idx;
                if (q_x >= cnt_qx) begin
                    status_next = ST_OUT_OF_RANGE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = q_idx[FI_W-1:WORD_SEL_W];
                end
            end
            S_FREE_RD: begin
                if (!row_word[idx_reg[WORD_SEL_W-1:0]]) begin
                    status_next = ST_NOT_IN_USE;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg[FI_W-1:WORD_SEL_W];
                    wr_data = row_word & ~(WORD_BITS'(1) << idx_reg[WORD_SEL_W-1:0]);
                    if (total_reg != '0) begin
                        total_next = total_reg - 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    idx_next   = {scan_addr_reg, found_pos};
                    wr_en      = 1'b1;
                    wr_addr    = scan_addr_reg;
                    wr_data    = row_word | (WORD_BITS'(1) << found_pos);
                    total_next = total_reg + 1'b1;
                    if (peak_reg < total_next) begin
                        peak_next = total_next;
                    end
                end else if (last_row) begin
                    status_next = ST_POOL_EMPTY;
                end else begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                    rd_en          = 1'b1;
                    rd_addr        = scan_addr_reg + 1'b1;
                end
            end
            S_OFS: begin
                res_ofs_next = ofs_prod[OFFSET_W-1:0];
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register: loads the result word when the slot is free or being emptied.
    always_comb begin
        m_valid_next        = m_valid_reg;
        m_alloc_offset_next = m_alloc_offset_reg;
        m_status_next       = m_status_reg;
        m_in_use_next       = m_in_use_reg;
        m_peak_next         = m_peak_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next        = 1'b1;
            m_alloc_offset_next = res_ofs_reg;
            m_status_next       = status_reg;
            m_in_use_next       = total_x[COUNT_W-1:0];
            m_peak_next         = peak_x[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            buffer_count_reg <= BUFFER_COUNT_RST;
            total_reg        <= '0;
            peak_reg         <= '0;
            m_valid_reg      <= 1'b0;
            row_valid_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            peak_reg    <= peak_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                buffer_count_reg <= cfg_wdata;
            end
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg           <= prod_next;
        scan_addr_reg      <= scan_addr_next;
        idx_reg            <= idx_next;
        status_reg         <= status_next;
        res_ofs_reg        <= res_ofs_next;
        m_alloc_offset_reg <= m_alloc_offset_next;
        m_status_reg       <= m_status_next;
        m_in_use_reg       <= m_in_use_next;
        m_peak_reg         <= m_peak_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= map_mem[rd_addr];
        end
    end

    // The row valid flag travels with the read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rvalid_reg <= 1'b0;
        end else if (rd_en) begin
            rvalid_reg <= row_valid_reg[rd_addr];
        end
    end

endmodule
